// File: rtl/cda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_pkg: shared types and calendar constants
// Sequencer states, control/status bundles and month/year length helpers.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int YEAR_W  = 7;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  localparam logic [YEAR_W-1:0]  LAST_YEAR  = 7'd99;
  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
  localparam logic [MONTH_W-1:0] FIRST_MONTH = 4'd1;
  localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd31;
  localparam logic [15:0]        RANGE_DAYS = 16'd36525;

  // One-hot sequencer states
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SUM_DAY  = 8'b0000_0010,
    S_SUM_YEAR = 8'b0000_0100,
    S_SUM_MON  = 8'b0000_1000,
    S_RANGE    = 8'b0001_0000,
    S_YEARS    = 8'b0010_0000,
    S_MONTHS   = 8'b0100_0000,
    S_OUT      = 8'b1000_0000
  } cda_state_t;

  // Top level to core
  typedef struct packed {
    logic start;      // item accepted this cycle
    logic slot_free;  // output register can take a result
  } cda_ctl_t;

  // Core to top level
  typedef struct packed {
    logic idle;
    logic done;       // result fields valid, waiting for slot
  } cda_sts_t;

  // Days in month m of year y; 0 for an invalid month
  function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0] y,
                                                  input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in year y
  function automatic logic [8:0] year_len(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) ? 9'd366 : 9'd365;
  endfunction

  // Days from year 0 day 1 to the first day of year y
  function automatic logic [15:0] year_start(input logic [YEAR_W-1:0] y);
    logic [15:0] base;
    logic [15:0] leaps;
    base  = 16'(y) * 16'd365;
    leaps = (16'(y) + 16'd3) >> 2;
    return base + leaps;
  endfunction

endpackage

// File: rtl/cda_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_alu: shared add / subtract-compare unit
// Adds or subtracts b from a; carry out set on subtract means a >= b.
// ----------------------------------------------------------------------------
module cda_alu #(
  parameter int AW = 17
) (
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  input  logic          sub,
  output logic [AW-1:0] res,
  output logic          carry
);

  logic [AW:0]   full;
  logic [AW-1:0] b_op;

  // Two's complement subtract via inverted operand and carry in
  assign b_op = sub ? ~b : b;
  assign full = {1'b0, a} + {1'b0, b_op} + {{AW{1'b0}}, sub};
  assign res   = full[AW-1:0];
  assign carry = full[AW];

endmodule

// File: rtl/cda_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_core: date advance sequencer and datapath
// Builds the day ordinal with the shared unit, checks range, then peels
// whole years and months off it one step per cycle.
// ----------------------------------------------------------------------------
module cda_core
  import cda_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cda_ctl_t               ctl,
  input  logic [YEAR_W-1:0]      start_year,
  input  logic [MONTH_W-1:0]     start_month,
  input  logic [DAY_W-1:0]       start_day,
  input  logic [COUNT_WIDTH-1:0] day_count,
  output cda_sts_t               sts,
  output logic [YEAR_W-1:0]      result_year,
  output logic [MONTH_W-1:0]     result_month,
  output logic [DAY_W-1:0]       result_day,
  output logic                   ok
);

  localparam int AW = COUNT_WIDTH + 1;

  cda_state_t          state_r, state_nxt;
  logic [AW-1:0]       acc_r, acc_nxt;
  logic [YEAR_W-1:0]   yr_r, yr_nxt;
  logic [MONTH_W-1:0]  mo_r, mo_nxt;
  logic [DAY_W-1:0]    day_r, day_nxt;
  logic [MONTH_W-1:0]  idx_r, idx_nxt;
  logic                ok_r, ok_nxt;

  logic [AW-1:0]       alu_b;
  logic                alu_sub;
  logic [AW-1:0]       alu_res;
  logic                alu_carry;
  logic [MONTH_W-1:0]  len_month;
  logic [DAY_W-1:0]    len_days;
  logic [DAY_W-1:0]    in_maxd;
  logic                in_valid_date;

  // Start date check
  assign in_maxd       = month_days(start_year, start_month);
  assign in_valid_date = (start_year <= LAST_YEAR) && (in_maxd != '0) &&
                         (start_day != '0) && (start_day <= in_maxd);

  // Month length lookup: loop index while summing, current month while peeling
  assign len_month = state_r[3] ? idx_r : mo_r;
  assign len_days  = month_days(yr_r, len_month);

  // Operand select for the shared unit
  always_comb begin
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_SUM_DAY:  alu_b = AW'(day_r - 5'd1);
      S_SUM_YEAR: alu_b = AW'(year_start(yr_r));
      S_SUM_MON:  alu_b = AW'(len_days);
      S_RANGE: begin
        alu_b   = AW'(RANGE_DAYS);
        alu_sub = 1'b1;
      end
      S_YEARS: begin
        alu_b   = AW'(year_len(yr_r));
        alu_sub = 1'b1;
      end
      S_MONTHS: begin
        alu_b   = AW'(len_days);
        alu_sub = 1'b1;
      end
      default: begin
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  cda_alu #(.AW(AW)) u_alu (
    .a     (acc_r),
    .b     (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .carry (alu_carry)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    yr_nxt    = yr_r;
    mo_nxt    = mo_r;
    day_nxt   = day_r;
    idx_nxt   = idx_r;
    ok_nxt    = ok_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          acc_nxt = AW'(day_count);
          yr_nxt  = start_year;
          mo_nxt  = start_month;
          day_nxt = start_day;
          idx_nxt = FIRST_MONTH;
          ok_nxt  = in_valid_date;
          state_nxt = in_valid_date ? S_SUM_DAY : S_OUT;
        end
      end
      S_SUM_DAY: begin
        acc_nxt   = alu_res;
        state_nxt = S_SUM_YEAR;
      end
      S_SUM_YEAR: begin
        acc_nxt   = alu_res;
        state_nxt = S_SUM_MON;
      end
      // Add lengths of the months before the start month
      S_SUM_MON: begin
        if (idx_r < mo_r) begin
          acc_nxt = alu_res;
          idx_nxt = idx_r + 4'd1;
        end else begin
          state_nxt = S_RANGE;
        end
      end
      // Past the last day: saturate
      S_RANGE: begin
        if (alu_carry) begin
          yr_nxt    = LAST_YEAR;
          mo_nxt    = LAST_MONTH;
          day_nxt   = LAST_DAY;
          ok_nxt    = 1'b0;
          state_nxt = S_OUT;
        end else begin
          yr_nxt    = '0;
          state_nxt = S_YEARS;
        end
      end
      S_YEARS: begin
        if ((yr_r < LAST_YEAR) && alu_carry) begin
          acc_nxt = alu_res;
          yr_nxt  = yr_r + 7'd1;
        end else begin
          mo_nxt    = FIRST_MONTH;
          state_nxt = S_MONTHS;
        end
      end
      S_MONTHS: begin
        if ((mo_r < LAST_MONTH) && alu_carry) begin
          acc_nxt = alu_res;
          mo_nxt  = mo_r + 4'd1;
        end else begin
          day_nxt   = acc_r[DAY_W-1:0] + 5'd1;
          ok_nxt    = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (ctl.slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    yr_r  <= yr_nxt;
    mo_r  <= mo_nxt;
    day_r <= day_nxt;
    idx_r <= idx_nxt;
    ok_r  <= ok_nxt;
  end

  assign sts.idle    = (state_r == S_IDLE);
  assign sts.done    = (state_r == S_OUT);
  assign result_year  = yr_r;
  assign result_month = mo_r;
  assign result_day   = day_r;
  assign ok           = ok_r;

endmodule

// File: rtl/calendar_date_advance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_advance: add a day count to a date in years 2000..2099
// Returns the advanced date and ok; errors give the start date or saturate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries a start date (year offset,
//   month, day) and a day count. Result channel out_valid/out_ready carries
//   the resulting date and ok. One result per item, in order.
//   From accept the core sums the start day, start year and earlier months,
//   checks range, then steps whole years and then months before out_valid;
//   an invalid start date skips to the result, and an overflowing one
//   saturates after the range check. The next item can be taken in the
//   cycle after a result loads. A single add/subtract unit walks whole
//   years then months one per cycle. One item is in work at a time;
//   in_ready is high only while the sequencer is idle.
//   The result sits in an output register, so a new item is accepted while
//   a finished result waits. If the receiver stalls with a result pending,
//   the next result holds in the core until the register frees up.
//   Synchronous active-low reset clears the sequencer and out_valid.
// ----------------------------------------------------------------------------
module calendar_date_advance
  import cda_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [YEAR_W-1:0]      in_start_year,
  input  logic [MONTH_W-1:0]     in_start_month,
  input  logic [DAY_W-1:0]       in_start_day,
  input  logic [COUNT_WIDTH-1:0] in_day_count,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [YEAR_W-1:0]      out_result_year,
  output logic [MONTH_W-1:0]     out_result_month,
  output logic [DAY_W-1:0]       out_result_day,
  output logic                   out_ok
);

  cda_ctl_t            ctl;
  cda_sts_t            sts;
  logic [YEAR_W-1:0]   core_year;
  logic [MONTH_W-1:0]  core_month;
  logic [DAY_W-1:0]    core_day;
  logic                core_ok;
  logic                out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0]   year_r;
  logic [MONTH_W-1:0]  month_r;
  logic [DAY_W-1:0]    day_r;
  logic                ok_r;
  logic                load_out;

  assign in_ready      = sts.idle;
  assign ctl.start     = in_valid && sts.idle;
  assign ctl.slot_free = !out_valid_r || out_ready;
  assign load_out      = sts.done && ctl.slot_free;

  cda_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .start_year   (in_start_year),
    .start_month  (in_start_month),
    .start_day    (in_start_day),
    .day_count    (in_day_count),
    .sts          (sts),
    .result_year  (core_year),
    .result_month (core_month),
    .result_day   (core_day),
    .ok           (core_ok)
  );

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      year_r  <= core_year;
      month_r <= core_month;
      day_r   <= core_day;
      ok_r    <= core_ok;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_year  = year_r;
  assign out_result_month = month_r;
  assign out_result_day   = day_r;
  assign out_ok           = ok_r;

endmodule

// File: rtl/cda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_checker: port-level checks for calendar_date_advance
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module cda_checker
  import cda_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [YEAR_W-1:0]  out_result_year,
  input logic [MONTH_W-1:0] out_result_month,
  input logic [DAY_W-1:0]   out_result_day,
  input logic               out_ok
);

  // A good result lies inside the calendar range
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ok) |-> (out_result_year <= LAST_YEAR) &&
      (out_result_month >= FIRST_MONTH) && (out_result_month <= LAST_MONTH) &&
      (out_result_day != '0))
    else $error("ok result outside calendar range");

  // Block is busy the cycle after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after accept");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_result_year) &&
      $stable(out_result_month) && $stable(out_result_day) && $stable(out_ok))
    else $error("stalled result changed");

  // Reset empties the result channel
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind calendar_date_advance cda_checker u_cda_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_year  (out_result_year),
  .out_result_month (out_result_month),
  .out_result_day   (out_result_day),
  .out_ok           (out_ok)
);
